FILE: rtl/core/pet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pet_pkg;

   // Default number of particle slots.
   localparam int POOL_SIZE_DEF = 64;

   // Random generator recurrence.
   localparam logic [31:0] LCG_MULT = 32'd1664525;
   localparam logic [31:0] LCG_INC  = 32'd1013904223;

   // One particle in the accumulator's Q20.12 format.
   localparam logic [31:0] ONE_PARTICLE = 32'h0000_1000;
   localparam logic [23:0] AGE_MAX      = 24'hFF_FFFF;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_EMISSION_RATE   = 3'd0,
      REG_PARTICLE_BUDGET = 3'd1,
      REG_LIFE_SPAN       = 3'd2,
      REG_SPAWN_POINT     = 3'd3,
      REG_SPEED_LOW       = 3'd4,
      REG_SPEED_HIGH      = 3'd5,
      REG_RANDOM_SEED     = 3'd6,
      REG_UNUSED          = 3'd7
   } reg_index_type;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ARM  = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_ZERO_STEP = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/core/pet_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module pet_mul (
   input  wire logic                              clock,
   input  wire logic signed [pet_pkg::MUL_A_W-1:0] op_a,
   input  wire logic signed [pet_pkg::MUL_B_W-1:0] op_b,
   output logic signed [pet_pkg::MUL_P_W-1:0]      product
);
   import pet_pkg::*;

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule
`default_nettype wire

FILE: rtl/core/particle_emitter_tick.sv
`timescale 1ns / 1ps
`default_nettype none
// One-shot particle emitter. An arm request clears the pool and starts the
// emitter; each tick request then accumulates rate times step, spawns
// particles into the lowest free slots while the budget allows, ages every
// live particle, retires those that reach the life span and moves the rest.
// All multiplications run through one shared, registered multiplier under a
// small sequencer, so the block takes one request at a time and holds
// req_stall high while it works. An arm request, a zero-step tick or a tick
// while disarmed goes straight to the finish step, which loads the response
// register. An armed tick runs the accumulate step, the spawn scan and the
// update sweep in that order. With a zero emission rate the accumulate and
// spawn steps are skipped. Each spawn spends a scan step and, per axis, a
// random step and a velocity draw, each through the multiplier and its
// output register; each moving particle spends a multiply and an add per
// axis. A finished response waits in its own register, and the next request
// is accepted while it is still stalled.
// The configuration registers are 64-bit words at byte address 8*i.
module particle_emitter_tick #(
   parameter int POOL_SIZE = pet_pkg::POOL_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [15:0] req_step_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [6:0]       rsp_spawned_now,
   output logic [6:0]       rsp_live_count,
   output logic [6:0]       rsp_total_spawned,
   output logic             rsp_emitter_running,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import pet_pkg::*;

   // Counters must hold the pool size itself and a 7-bit budget.
   localparam int CNT_W = ($clog2(POOL_SIZE + 1) > 7) ? $clog2(POOL_SIZE + 1) : 7;
   localparam int IW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC_MUL, ST_ACC_ADD, ST_SCAN, ST_LCG_MUL, ST_LCG_ADD,
      ST_DRAW_MUL, ST_DRAW_ADD, ST_UPD_RD, ST_UPD_AGE, ST_MOV_MUL,
      ST_MOV_ADD, ST_FINISH
   } state_type;

   // Configuration registers.
   logic [23:0] rate_ff, rate_in;
   logic [6:0]  budget_ff, budget_in;
   logic [23:0] life_ff, life_in;
   logic [47:0] spawn_ff, spawn_in;
   logic [47:0] slow_ff, slow_in;
   logic [47:0] shigh_ff, shigh_in;
   logic [31:0] seed_ff, seed_in;

   // Sequencer and emitter state.
   state_type       state_ff, state_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [1:0]      axis_ff, axis_in;
   logic [15:0]     step_ff, step_in;
   logic [31:0]     acc_ff, acc_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] spawned_ff, spawned_in;
   logic [CNT_W-1:0] live_cnt_ff, live_cnt_in;
   logic [POOL_SIZE-1:0] live_ff, live_in;
   logic            armed_ff, armed_in;
   logic [31:0]     lcg_ff, lcg_in;
   logic            res_status_ff, res_status_in;

   // Response register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_status_ff, rsp_status_in;
   logic [6:0]      rsp_spawned_ff, rsp_spawned_in;
   logic [6:0]      rsp_live_ff, rsp_live_in;
   logic [6:0]      rsp_total_ff, rsp_total_in;
   logic            rsp_run_ff, rsp_run_in;

   // Particle store, one read and one write per cycle, both at the pointer.
   logic [31:0] pos_x_mem [POOL_SIZE];
   logic [31:0] pos_y_mem [POOL_SIZE];
   logic [31:0] pos_z_mem [POOL_SIZE];
   logic [15:0] vel_x_mem [POOL_SIZE];
   logic [15:0] vel_y_mem [POOL_SIZE];
   logic [15:0] vel_z_mem [POOL_SIZE];
   logic [23:0] age_mem   [POOL_SIZE];
   logic [31:0] pos_x_rd_ff, pos_y_rd_ff, pos_z_rd_ff;
   logic [15:0] vel_x_rd_ff, vel_y_rd_ff, vel_z_rd_ff;
   logic [23:0] age_rd_ff;

   logic        pos_x_we, pos_y_we, pos_z_we;
   logic [31:0] pos_x_wd, pos_y_wd, pos_z_wd;
   logic        vel_x_we, vel_y_we, vel_z_we;
   logic [15:0] vel_wd;
   logic        age_we;
   logic [23:0] age_wd;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic             cfg_write;
   reg_index_type    cfg_idx;
   logic             req_accept;
   logic [IW-1:0]    ptr_idx;
   logic [CNT_W-1:0] budget_eff;
   logic [15:0]      sel_low, sel_high, sel_vel;
   logic [31:0]      sel_pos;
   logic [32:0]      acc_sum;
   logic [24:0]      age_sum;
   logic [23:0]      age_sat;
   logic [31:0]      spawn_x, spawn_y, spawn_z;
   logic [31:0]      move_pos;
   logic [15:0]      draw_vel;

   pet_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign cfg_write  = psel && penable && pwrite;
   assign cfg_idx    = reg_index_type'(paddr[5:3]);
   assign pready     = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign ptr_idx    = ptr_ff[IW-1:0];

   assign budget_eff = (CNT_W'(budget_ff) < POOL_CNT) ? CNT_W'(budget_ff) : POOL_CNT;

   always_comb begin
      case (cfg_idx)
         REG_EMISSION_RATE:   prdata = 64'(rate_ff);
         REG_PARTICLE_BUDGET: prdata = 64'(budget_ff);
         REG_LIFE_SPAN:       prdata = 64'(life_ff);
         REG_SPAWN_POINT:     prdata = 64'(spawn_ff);
         REG_SPEED_LOW:       prdata = 64'(slow_ff);
         REG_SPEED_HIGH:      prdata = 64'(shigh_ff);
         REG_RANDOM_SEED:     prdata = 64'(seed_ff);
         default:             prdata = 64'd0;
      endcase
   end

   // Per-axis selection of the velocity bounds and the stored particle.
   always_comb begin
      case (axis_ff)
         2'd0: begin
            sel_low = slow_ff[15:0];   sel_high = shigh_ff[15:0];
            sel_vel = vel_x_rd_ff;     sel_pos  = pos_x_rd_ff;
         end
         2'd1: begin
            sel_low = slow_ff[31:16];  sel_high = shigh_ff[31:16];
            sel_vel = vel_y_rd_ff;     sel_pos  = pos_y_rd_ff;
         end
         default: begin
            sel_low = slow_ff[47:32];  sel_high = shigh_ff[47:32];
            sel_vel = vel_z_rd_ff;     sel_pos  = pos_z_rd_ff;
         end
      endcase
   end

   // Spawn position is Q8.8 sign-extended into Q16.16.
   assign spawn_x = {{8{spawn_ff[15]}}, spawn_ff[15:0], 8'd0};
   assign spawn_y = {{8{spawn_ff[31]}}, spawn_ff[31:16], 8'd0};
   assign spawn_z = {{8{spawn_ff[47]}}, spawn_ff[47:32], 8'd0};

   assign acc_sum = 33'(acc_ff) + 33'(mul_p[39:8]);
   assign age_sum = 25'(age_rd_ff) + 25'({step_ff, 4'd0});
   assign age_sat = age_sum[24] ? AGE_MAX : age_sum[23:0];

   // Arithmetic shifts floor the signed products.
   assign draw_vel = sel_low + 16'(mul_p >>> 24);
   assign move_pos = sel_pos + 32'(mul_p >>> 4);

   always_comb begin
      rate_in       = rate_ff;
      budget_in     = budget_ff;
      life_in       = life_ff;
      spawn_in      = spawn_ff;
      slow_in       = slow_ff;
      shigh_in      = shigh_ff;
      seed_in       = seed_ff;
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      axis_in       = axis_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;
      spawned_in    = spawned_ff;
      live_cnt_in   = live_cnt_ff;
      live_in       = live_ff;
      armed_in      = armed_ff;
      lcg_in        = lcg_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_spawned_in = rsp_spawned_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_run_in     = rsp_run_ff;
      mul_a    = '0;
      mul_b    = '0;
      pos_x_we = 1'b0;  pos_y_we = 1'b0;  pos_z_we = 1'b0;
      pos_x_wd = spawn_x;
      pos_y_wd = spawn_y;
      pos_z_wd = spawn_z;
      vel_x_we = 1'b0;  vel_y_we = 1'b0;  vel_z_we = 1'b0;
      vel_wd   = draw_vel;
      age_we   = 1'b0;
      age_wd   = 24'd0;

      if (cfg_write) begin
         case (cfg_idx)
            REG_EMISSION_RATE:   rate_in   = pwdata[23:0];
            REG_PARTICLE_BUDGET: budget_in = pwdata[6:0];
            REG_LIFE_SPAN:       life_in   = pwdata[23:0];
            REG_SPAWN_POINT:     spawn_in  = pwdata[47:0];
            REG_SPEED_LOW:       slow_in   = pwdata[47:0];
            REG_SPEED_HIGH:      shigh_in  = pwdata[47:0];
            REG_RANDOM_SEED: begin
               seed_in = pwdata[31:0];
               lcg_in  = pwdata[31:0];
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               step_in       = req_step_time;
               spawned_in    = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_FINISH;
               if (req_type == REQ_ARM) begin
                  live_in     = '0;
                  live_cnt_in = '0;
                  total_in    = '0;
                  acc_in      = '0;
                  armed_in    = 1'b1;
               end else if (req_step_time == 16'd0) begin
                  res_status_in = STATUS_ZERO_STEP;
               end else if (armed_ff) begin
                  ptr_in   = '0;
                  state_in = (rate_ff != 24'd0) ? ST_ACC_MUL : ST_UPD_RD;
               end
            end
         end
         ST_ACC_MUL: begin
            mul_a    = MUL_A_W'(rate_ff);
            mul_b    = MUL_B_W'(step_ff);
            state_in = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            acc_in   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // The pointer only moves up: slots below it stay filled.
            if (acc_ff >= ONE_PARTICLE && total_ff < budget_eff) begin
               if (ptr_ff >= budget_eff) begin
                  ptr_in   = '0;
                  state_in = ST_UPD_RD;
               end else if (live_ff[ptr_idx]) begin
                  ptr_in = ptr_ff + 1'b1;
               end else begin
                  axis_in  = 2'd0;
                  state_in = ST_LCG_MUL;
               end
            end else begin
               ptr_in   = '0;
               state_in = ST_UPD_RD;
            end
         end
         ST_LCG_MUL: begin
            mul_a    = MUL_A_W'(lcg_ff);
            mul_b    = MUL_B_W'(LCG_MULT);
            state_in = ST_LCG_ADD;
         end
         ST_LCG_ADD: begin
            lcg_in   = mul_p[31:0] + LCG_INC;
            state_in = ST_DRAW_MUL;
         end
         ST_DRAW_MUL: begin
            mul_a    = MUL_A_W'($signed({sel_high[15], sel_high})
                                - $signed({sel_low[15], sel_low}));
            mul_b    = MUL_B_W'({1'b0, lcg_ff[31:8]});
            state_in = ST_DRAW_ADD;
         end
         ST_DRAW_ADD: begin
            case (axis_ff)
               2'd0:    vel_x_we = 1'b1;
               2'd1:    vel_y_we = 1'b1;
               default: vel_z_we = 1'b1;
            endcase
            if (axis_ff == 2'd2) begin
               pos_x_we = 1'b1;
               pos_y_we = 1'b1;
               pos_z_we = 1'b1;
               age_we   = 1'b1;
               live_in[ptr_idx] = 1'b1;
               live_cnt_in = live_cnt_ff + 1'b1;
               acc_in      = acc_ff - ONE_PARTICLE;
               total_in    = total_ff + 1'b1;
               spawned_in  = spawned_ff + 1'b1;
               ptr_in      = ptr_ff + 1'b1;
               state_in    = ST_SCAN;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_LCG_MUL;
            end
         end
         ST_UPD_RD: begin
            // The particle store is read at the pointer every cycle.
            if (ptr_ff == POOL_CNT) begin
               if (live_cnt_ff == '0 && total_ff >= budget_eff) begin
                  armed_in = 1'b0;
               end
               state_in = ST_FINISH;
            end else if (live_ff[ptr_idx]) begin
               state_in = ST_UPD_AGE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_UPD_AGE: begin
            age_we = 1'b1;
            age_wd = age_sat;
            if (age_sat >= life_ff) begin
               live_in[ptr_idx] = 1'b0;
               live_cnt_in = live_cnt_ff - 1'b1;
               ptr_in      = ptr_ff + 1'b1;
               state_in    = ST_UPD_RD;
            end else begin
               axis_in  = 2'd0;
               state_in = ST_MOV_MUL;
            end
         end
         ST_MOV_MUL: begin
            mul_a    = MUL_A_W'($signed(sel_vel));
            mul_b    = MUL_B_W'(step_ff);
            state_in = ST_MOV_ADD;
         end
         ST_MOV_ADD: begin
            pos_x_wd = move_pos;
            pos_y_wd = move_pos;
            pos_z_wd = move_pos;
            case (axis_ff)
               2'd0:    pos_x_we = 1'b1;
               2'd1:    pos_y_we = 1'b1;
               default: pos_z_we = 1'b1;
            endcase
            if (axis_ff == 2'd2) begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_UPD_RD;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_MOV_MUL;
            end
         end
         ST_FINISH: begin
            // Wait here only while the previous response is still stalled.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_spawned_in = spawned_ff[6:0];
               rsp_live_in    = live_cnt_ff[6:0];
               rsp_total_in   = total_ff[6:0];
               rsp_run_in     = armed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= 24'd0;
         budget_ff    <= 7'd0;
         life_ff      <= 24'h01_0000;
         spawn_ff     <= 48'd0;
         slow_ff      <= 48'd0;
         shigh_ff     <= 48'd0;
         seed_ff      <= 32'd0;
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         axis_ff      <= 2'd0;
         acc_ff       <= 32'd0;
         total_ff     <= '0;
         spawned_ff   <= '0;
         live_cnt_ff  <= '0;
         live_ff      <= '0;
         armed_ff     <= 1'b0;
         lcg_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         budget_ff    <= budget_in;
         life_ff      <= life_in;
         spawn_ff     <= spawn_in;
         slow_ff      <= slow_in;
         shigh_ff     <= shigh_in;
         seed_ff      <= seed_in;
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         axis_ff      <= axis_in;
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         spawned_ff   <= spawned_in;
         live_cnt_ff  <= live_cnt_in;
         live_ff      <= live_in;
         armed_ff     <= armed_in;
         lcg_ff       <= lcg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff        <= step_in;
      res_status_ff  <= res_status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_spawned_ff <= rsp_spawned_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_run_ff     <= rsp_run_in;
   end

   always_ff @(posedge clock) begin
      if (pos_x_we) pos_x_mem[ptr_idx] <= pos_x_wd;
      if (pos_y_we) pos_y_mem[ptr_idx] <= pos_y_wd;
      if (pos_z_we) pos_z_mem[ptr_idx] <= pos_z_wd;
      if (vel_x_we) vel_x_mem[ptr_idx] <= vel_wd;
      if (vel_y_we) vel_y_mem[ptr_idx] <= vel_wd;
      if (vel_z_we) vel_z_mem[ptr_idx] <= vel_wd;
      if (age_we)   age_mem[ptr_idx]   <= age_wd;
      pos_x_rd_ff <= pos_x_mem[ptr_idx];
      pos_y_rd_ff <= pos_y_mem[ptr_idx];
      pos_z_rd_ff <= pos_z_mem[ptr_idx];
      vel_x_rd_ff <= vel_x_mem[ptr_idx];
      vel_y_rd_ff <= vel_y_mem[ptr_idx];
      vel_z_rd_ff <= vel_z_mem[ptr_idx];
      age_rd_ff   <= age_mem[ptr_idx];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_spawned_now     = rsp_spawned_ff;
   assign rsp_live_count      = rsp_live_ff;
   assign rsp_total_spawned   = rsp_total_ff;
   assign rsp_emitter_running = rsp_run_ff;

   // The running live count always matches the valid bits.
   assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff == CNT_W'($countones(live_ff)))
      else $error("live count out of step with slot valid bits");

   // Spawning and updating happen only while the emitter is armed; this checks the spawn scan and spawn write steps.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAW_ADD) |-> armed_ff)
      else $error("spawn sequence running while disarmed");

   // A new response is only ever loaded from the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");
endmodule
`default_nettype wire
